FILE: rtl/ptbd_pkg.sv
// ----------------------------------------------------------------------------
// ptbd_pkg
// shared types and constants for the point to box distance core
// ----------------------------------------------------------------------------
package ptbd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    // coordinates are q15.8; the scale passes through the datapath unchanged
    localparam int FRAC_BITS_DEF   = 8;
    localparam int CW              = COORD_WIDTH_DEF;
    localparam int DIST_WIDTH      = 25;
    localparam int ADDR_WIDTH      = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [ADDR_WIDTH-1:0] ADDR_CAM_X = 4'h0;
    localparam logic [ADDR_WIDTH-1:0] ADDR_CAM_Y = 4'h4;
    localparam logic [ADDR_WIDTH-1:0] ADDR_CAM_Z = 4'h8;

    typedef struct packed {
        logic                 has_volume;
        logic signed [CW-1:0] box_min_x;
        logic signed [CW-1:0] box_min_y;
        logic signed [CW-1:0] box_min_z;
        logic signed [CW-1:0] box_max_x;
        logic signed [CW-1:0] box_max_y;
        logic signed [CW-1:0] box_max_z;
        logic signed [CW-1:0] offset_x;
        logic signed [CW-1:0] offset_y;
        logic signed [CW-1:0] offset_z;
    } t_in_item;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic                  inside_res;
        logic                  no_volume;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [CW-1:0] gap_x;
        logic [CW-1:0] gap_y;
        logic [CW-1:0] gap_z;
        logic          in_box;
        logic          no_volume;
    } t_gap_item;

endpackage

FILE: rtl/ptbd_front.sv
// ----------------------------------------------------------------------------
// ptbd_front
// translates the box, saturates, and finds the per-axis gap to the camera
// ----------------------------------------------------------------------------
module ptbd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  ptbd_pkg::t_in_item     i_item,
    input  logic [ptbd_pkg::CW-1:0] i_cam_x,
    input  logic [ptbd_pkg::CW-1:0] i_cam_y,
    input  logic [ptbd_pkg::CW-1:0] i_cam_z,
    output logic                   o_valid,
    input  logic                   i_ready,
    output ptbd_pkg::t_gap_item    o_item
);
    localparam int CW = ptbd_pkg::CW;

    logic              r_valid;
    ptbd_pkg::t_gap_item r_item;
    ptbd_pkg::t_gap_item n_item;

    function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1])
            return s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        return s[CW-1:0];
    endfunction

    // gap fits in CW bits unsigned since both terms are in range
    function automatic logic [CW:0] axis_gap(input logic signed [CW-1:0] cam,
                                            input logic signed [CW-1:0] mn,
                                            input logic signed [CW-1:0] mx);
        logic signed [CW:0] d;
        if (cam <= mn) begin
            d = {mn[CW-1], mn} - {cam[CW-1], cam};
            return {1'b0, d[CW-1:0]};
        end
        if (cam > mx) begin
            d = {cam[CW-1], cam} - {mx[CW-1], mx};
            return {1'b0, d[CW-1:0]};
        end
        return {1'b1, {CW{1'b0}}};
    endfunction

    logic [CW:0] w_gx, w_gy, w_gz;

    always_comb begin
        w_gx = axis_gap(i_cam_x, sat_add(i_item.box_min_x, i_item.offset_x),
                        sat_add(i_item.box_max_x, i_item.offset_x));
        w_gy = axis_gap(i_cam_y, sat_add(i_item.box_min_y, i_item.offset_y),
                        sat_add(i_item.box_max_y, i_item.offset_y));
        w_gz = axis_gap(i_cam_z, sat_add(i_item.box_min_z, i_item.offset_z),
                        sat_add(i_item.box_max_z, i_item.offset_z));
        n_item.no_volume = !i_item.has_volume;
        if (i_item.has_volume) begin
            n_item.gap_x  = w_gx[CW-1:0];
            n_item.gap_y  = w_gy[CW-1:0];
            n_item.gap_z  = w_gz[CW-1:0];
            n_item.in_box = w_gx[CW] & w_gy[CW] & w_gz[CW];
        end else begin
            n_item.gap_x  = '0;
            n_item.gap_y  = '0;
            n_item.gap_z  = '0;
            n_item.in_box = 1'b0;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end
endmodule

FILE: rtl/ptbd_queue.sv
// ----------------------------------------------------------------------------
// ptbd_queue
// small fifo between front and back
// ----------------------------------------------------------------------------
module ptbd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ptbd_pkg::t_gap_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output ptbd_pkg::t_gap_item o_item
);
    localparam int D  = ptbd_pkg::QUEUE_DEPTH;
    localparam int AW = (D > 1) ? $clog2(D) : 1;

    ptbd_pkg::t_gap_item r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_ready = r_cnt != (AW+1)'(D);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(D-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(D-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

FILE: rtl/ptbd_back.sv
// ----------------------------------------------------------------------------
// ptbd_back
// sum of squares then pipelined restoring square root, one bit per stage
// ----------------------------------------------------------------------------
module ptbd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ptbd_pkg::t_gap_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output ptbd_pkg::t_out_item o_item
);
    localparam int CW = ptbd_pkg::CW;
    localparam int SW = 2*CW + 2;          // sum of three squares
    localparam int RW = CW + 1;            // root width
    localparam int NS = RW;                // one root bit per stage

    typedef struct packed {
        logic          vld;
        logic [SW-1:0] rem;
        logic [RW-1:0] root;
        logic          in_box;
        logic          novol;
    } t_stage;

    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // stage a: squares
    logic            r_sv;
    logic [2*CW-1:0] r_sqx, r_sqy, r_sqz;
    logic            r_sin, r_snv;
    t_stage          r_st [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (w_adv) begin
            r_sv <= i_valid;
        end
        if (w_adv) begin
            r_sqx <= i_item.gap_x * i_item.gap_x;
            r_sqy <= i_item.gap_y * i_item.gap_y;
            r_sqz <= i_item.gap_z * i_item.gap_z;
            r_sin <= i_item.in_box;
            r_snv <= i_item.no_volume;
        end
    end

    // stage b: sum, then root bits msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_st[0].vld <= r_sv;
        end
        if (w_adv) begin
            r_st[0].rem    <= SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz);
            r_st[0].root   <= '0;
            r_st[0].in_box <= r_sin;
            r_st[0].novol  <= r_snv;
        end
    end

    // rem holds the sum minus root squared; setting bit B adds
    // root * 2^(B+1) + 2^(2B) to the square
    for (genvar g = 0; g < NS; g++) begin : g_root
        localparam int B = NS - 1 - g;
        logic [SW-1:0] w_trial;
        logic [RW-1:0] w_cand;
        always_comb begin
            w_cand  = r_st[g].root | (RW'(1) << B);
            w_trial = (SW'(r_st[g].root) << (B + 1)) | (SW'(1) << (2 * B));
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[g+1].vld <= 1'b0;
            end else if (w_adv) begin
                r_st[g+1].vld <= r_st[g].vld;
            end
            if (w_adv) begin
                r_st[g+1].rem    <= (w_trial <= r_st[g].rem) ? r_st[g].rem - w_trial
                                                             : r_st[g].rem;
                r_st[g+1].root   <= (w_trial <= r_st[g].rem) ? w_cand : r_st[g].root;
                r_st[g+1].in_box <= r_st[g].in_box;
                r_st[g+1].novol  <= r_st[g].novol;
            end
        end
    end

    assign o_valid            = r_st[NS].vld;
    assign o_item.distance    = ptbd_pkg::DIST_WIDTH'(r_st[NS].root);
    assign o_item.inside_res  = r_st[NS].in_box;
    assign o_item.no_volume   = r_st[NS].novol;
endmodule

FILE: rtl/point_to_box_distance_core.sv
// ----------------------------------------------------------------------------
// point_to_box_distance_core
// euclidean distance from a camera point to a translated axis-aligned box
// ----------------------------------------------------------------------------
// usage:
//   camera x, y, z are written over the apb port at 0x0, 0x4, 0x8 while idle
//   input items (box corners, offset, has_volume) enter on i_in_valid/o_in_ready
//   result items (distance, inside_res, no_volume) leave on o_out_valid/i_out_ready
// pipeline: the accepting edge loads the front stage, then the item passes the queue,
//   the squares and sum registers, then 25 root stages, one root bit each
// throughput: one item per cycle while the receiver keeps ready high, set by the pipelined square root
// reset: clears all valid flags and the camera registers to zero
// stall: when the receiver holds ready low the root pipeline freezes, the
//   queue fills, and then the front stops taking items; nothing is dropped
// ----------------------------------------------------------------------------
module point_to_box_distance_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptbd_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ptbd_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ptbd_pkg::t_out_item               o_out_item
);
    localparam int CW = ptbd_pkg::CW;

    // fixed-point scale passes through unchanged; widths are set by the package
    logic [CW-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else if (w_wr) begin
            case (paddr)
                ptbd_pkg::ADDR_CAM_X: r_cam_x <= pwdata[CW-1:0];
                ptbd_pkg::ADDR_CAM_Y: r_cam_y <= pwdata[CW-1:0];
                ptbd_pkg::ADDR_CAM_Z: r_cam_z <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // reads return the sign-extended register
    always_comb begin
        case (paddr)
            ptbd_pkg::ADDR_CAM_X: prdata = 32'(signed'(r_cam_x));
            ptbd_pkg::ADDR_CAM_Y: prdata = 32'(signed'(r_cam_y));
            ptbd_pkg::ADDR_CAM_Z: prdata = 32'(signed'(r_cam_z));
            default:              prdata = '0;
        endcase
    end

    // front to queue, queue to back
    logic                w_fv, w_fr, w_qv, w_qr;
    ptbd_pkg::t_gap_item w_fitem, w_qitem;

    ptbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_cam_x (r_cam_x),
        .i_cam_y (r_cam_y),
        .i_cam_z (r_cam_z),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_item  (w_fitem)
    );

    ptbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_item  (w_fitem),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_item  (w_qitem)
    );

    ptbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .o_ready (w_qr),
        .i_item  (w_qitem),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // a result never flags both inside and missing box
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.inside_res && o_out_item.no_volume))
        else $error("inside and no_volume both set");

    // flagged results carry zero distance
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.inside_res || o_out_item.no_volume))
            |-> o_out_item.distance == '0)
        else $error("nonzero distance on flagged result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");
endmodule

FILE: dv/point_to_box_distance_core_test.sv
// ----------------------------------------------------------------------------
// point_to_box_distance_core_test
// streams boxes through the core against a local distance predictor
// ----------------------------------------------------------------------------
// camera registers are set over apb while idle, then directed and random items
// are pushed with random gaps on both sides; every result item is checked
// field by field against the oldest predicted result
// ----------------------------------------------------------------------------
module point_to_box_distance_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 40;
    localparam int CYCLE_CAP  = 400000;
    localparam int COORD_HI   = 8388607;
    localparam int COORD_LO   = -8388608;
    localparam int CW         = ptbd_pkg::CW;
    localparam int AW         = ptbd_pkg::ADDR_WIDTH;
    localparam int DW         = ptbd_pkg::DIST_WIDTH;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    ptbd_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    ptbd_pkg::t_out_item o_out_item;

    point_to_box_distance_core dut (.*);

    always #1 i_clk = ~i_clk;

    // camera copy used by the predictor
    longint cam_pos [3];

    ptbd_pkg::t_in_item  box_queue [$];
    ptbd_pkg::t_out_item dist_queue [$];
    int mismatches = 0;
    int cycle_count = 0;
    bit phase_busy = 0;

    function automatic longint sat_coord(longint a, longint b);
        longint s;
        s = a + b;
        if (s > COORD_HI) return COORD_HI;
        if (s < COORD_LO) return COORD_LO;
        return s;
    endfunction

    // gap on one axis, flags inside (above min and at most max)
    function automatic longint face_gap(longint c, longint mn, longint mx, output bit in_ax);
        in_ax = 0;
        if (c <= mn) return mn - c;
        if (c > mx) return c - mx;
        in_ax = 1;
        return 0;
    endfunction

    function automatic longint floor_root(bit [127:0] v);
        bit [127:0] r;
        bit [127:0] c;
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= v) r = c;
        end
        return longint'(r);
    endfunction

    function automatic ptbd_pkg::t_out_item predict_distance(ptbd_pkg::t_in_item it);
        ptbd_pkg::t_out_item res;
        longint mn [3], mx [3], of [3], g;
        bit in_ax [3];
        bit [127:0] acc;
        longint d;
        res = '0;
        if (!it.has_volume) begin
            res.no_volume = 1'b1;
            return res;
        end
        of[0] = it.offset_x; of[1] = it.offset_y; of[2] = it.offset_z;
        mn[0] = sat_coord(it.box_min_x, of[0]);
        mn[1] = sat_coord(it.box_min_y, of[1]);
        mn[2] = sat_coord(it.box_min_z, of[2]);
        mx[0] = sat_coord(it.box_max_x, of[0]);
        mx[1] = sat_coord(it.box_max_y, of[1]);
        mx[2] = sat_coord(it.box_max_z, of[2]);
        acc = 0;
        for (int a = 0; a < 3; a++) begin
            g = face_gap(cam_pos[a], mn[a], mx[a], in_ax[a]);
            acc += 128'(g) * 128'(g);
        end
        d = floor_root(acc);
        if (d > 33554431) d = 33554431;
        res.distance = d[DW-1:0];
        res.inside_res = in_ax[0] && in_ax[1] && in_ax[2];
        return res;
    endfunction

    // driver: one item at a time with a random gap before each
    int gap_in = 0;
    int next_gap;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            dist_queue.push_back(predict_distance(i_in_item));
            void'(box_queue.pop_front());
            next_gap = $urandom_range(0, 5);
            if (next_gap == 0 && box_queue.size() > 0 && phase_busy) begin
                i_in_item <= box_queue[0];
                gap_in <= 0;
            end else begin
                i_in_valid <= 1'b0;
                gap_in <= (next_gap > 0) ? next_gap - 1 : 0;
            end
        end else if (!i_in_valid && i_rst_n) begin
            if (gap_in > 0) begin
                gap_in <= gap_in - 1;
            end else if (box_queue.size() > 0 && phase_busy) begin
                i_in_item <= box_queue[0];
                i_in_valid <= 1'b1;
            end
        end
    end

    // monitor: random ready stalls, compare with oldest prediction
    int gap_out = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL point_to_box_distance_core");
            $finish;
        end
        if (o_out_valid && i_out_ready) begin
            if (dist_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", o_out_item);
            end else begin
                if (o_out_item !== dist_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", dist_queue[0], o_out_item);
                end
                void'(dist_queue.pop_front());
            end
            gap_out = $urandom_range(0, 5);
        end
        if (gap_out > 0) begin
            gap_out--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n;
        end
    end

    task automatic write_cam(int idx, longint v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= AW'(idx * 4);
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cam_pos[idx] = v;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($urandom_range(0, 4000)) - CW'(2000);
            default: return CW'($urandom_range(0, 200000)) - CW'(100000);
        endcase
    endfunction

    task automatic add_box(bit hv, longint mnx, longint mny, longint mnz,
                           longint mxx, longint mxy, longint mxz,
                           longint ox, longint oy, longint oz);
        ptbd_pkg::t_in_item it;
        it.has_volume = hv;
        it.box_min_x = CW'(mnx); it.box_min_y = CW'(mny); it.box_min_z = CW'(mnz);
        it.box_max_x = CW'(mxx); it.box_max_y = CW'(mxy); it.box_max_z = CW'(mxz);
        it.offset_x = CW'(ox); it.offset_y = CW'(oy); it.offset_z = CW'(oz);
        box_queue.push_back(it);
    endtask

    // let the queued items drain and all their results arrive, then idle before the next phase
    task automatic run_phase();
        phase_busy = 1;
        wait (box_queue.size() == 0 && !i_in_valid && dist_queue.size() == 0);
        phase_busy = 0;
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic random_boxes(int n);
        ptbd_pkg::t_in_item it;
        logic [255:0] raw;
        int mode;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(0, 2);
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom};
            it = raw[$bits(ptbd_pkg::t_in_item)-1:0];
            it.has_volume = ($urandom_range(0, 9) != 0);
            if (mode != 0) begin
                it.box_min_x = rand_coord(mode); it.box_max_x = rand_coord(mode);
                it.box_min_y = rand_coord(mode); it.box_max_y = rand_coord(mode);
                it.box_min_z = rand_coord(mode); it.box_max_z = rand_coord(mode);
                it.offset_x = rand_coord(mode); it.offset_y = rand_coord(mode);
                it.offset_z = rand_coord(mode);
            end
            box_queue.push_back(it);
        end
    endtask

    initial begin
        cam_pos[0] = 0; cam_pos[1] = 0; cam_pos[2] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cam(0, 0); write_cam(1, 0); write_cam(2, 0);

        // missing box, inside, on a face, inverted box, saturation, extremes
        add_box(0, 5, 5, 5, 9, 9, 9, 1, 1, 1);
        add_box(1, -100, -100, -100, 100, 100, 100, 0, 0, 0);
        add_box(1, 0, -10, -10, 10, 10, 10, 0, 0, 0);
        add_box(1, 50, -10, -10, -50, 10, 10, 0, 0, 0);
        add_box(1, -50, -10, -10, -60, 10, 10, 0, 0, 0);
        add_box(1, 300, 400, 0, 500, 600, 700, 0, 0, 0);
        add_box(1, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                COORD_HI, COORD_HI, COORD_HI);
        add_box(1, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                COORD_LO, COORD_LO, COORD_LO);
        add_box(1, COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, 0, 0, 0);
        add_box(1, 10, 20, 30, 40, 50, 60, -5, -6, -7);
        run_phase();

        write_cam(0, COORD_HI); write_cam(1, COORD_LO); write_cam(2, COORD_HI);
        add_box(1, COORD_LO, COORD_HI, COORD_LO, COORD_LO, COORD_HI, COORD_LO, 0, 0, 0);
        add_box(1, 0, 0, 0, 0, 0, 0, COORD_LO, COORD_HI, COORD_LO);
        add_box(1, COORD_HI, COORD_LO, COORD_HI, COORD_HI, COORD_LO, COORD_HI, 0, 0, 0);
        add_box(1, 0, 0, 0, 1, 1, 1, COORD_HI, COORD_HI, COORD_HI);
        random_boxes(300);
        run_phase();

        write_cam(0, COORD_LO); write_cam(1, COORD_HI); write_cam(2, COORD_LO);
        random_boxes(300);
        run_phase();

        for (int p = 0; p < 3; p++) begin
            write_cam(0, int'($urandom_range(0, 4000)) - 2000);
            write_cam(1, longint'(rand_coord($urandom_range(0, 2))));
            write_cam(2, int'($urandom_range(0, 4000)) - 2000);
            random_boxes(185);
            run_phase();
        end

        if (mismatches == 0) begin
            $display("PASS point_to_box_distance_core");
        end else begin
            $display("FAIL point_to_box_distance_core");
        end
        $finish;
    end

endmodule

FILE: point_to_box_distance_core.f
rtl/ptbd_pkg.sv
rtl/ptbd_front.sv
rtl/ptbd_queue.sv
rtl/ptbd_back.sv
rtl/point_to_box_distance_core.sv
dv/point_to_box_distance_core_test.sv
